@@ src/atcs_pkg.sv @@
`default_nettype none

package atcs_pkg;

    // Kinds of input word, carried on the input tuser.
    typedef enum logic [1:0] {
        CMD_QUEUE = 2'd0,
        CMD_BYTE  = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NONE  = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        ST_READY   = 2'd0,
        ST_WAIT    = 2'd1,
        ST_GOT     = 2'd2,
        ST_TIMEOUT = 2'd3
    } fsm_state_t;

    // Reply codes. The code of a keyword is its place in the keyword list.
    localparam logic [2:0] RC_READY   = 3'd0;
    localparam logic [2:0] RC_OK      = 3'd1;
    localparam logic [2:0] RC_SEND_OK = 3'd2;
    localparam logic [2:0] RC_BUSY    = 3'd3;
    localparam logic [2:0] RC_FAIL    = 3'd4;
    localparam logic [2:0] RC_ERROR   = 3'd5;
    localparam logic [2:0] RC_UNKNOWN = 3'd6;

    // Restart causes reported on the result word.
    localparam logic [1:0] CAUSE_NONE  = 2'd0;
    localparam logic [1:0] CAUSE_ERROR = 2'd1;
    localparam logic [1:0] CAUSE_FAIL  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_RESET_HANDLE = 1'b0;
    localparam logic CFG_TIMEOUT      = 1'b1;

    localparam int          NumKeys      = 6;
    localparam logic [5:0]  PosMax       = 6'd63;
    localparam logic [7:0]  TimeoutReset = 8'd5;

    typedef struct packed {
        logic       push;
        logic [7:0] push_data;
        logic       pop;
    } queue_req_t;

    typedef struct packed {
        logic       push_ok;
        logic       pop_ok;
        logic [7:0] pop_data;
    } queue_status_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] code;
    } match_t;

    // Length of each reply keyword, line ending included.
    function automatic logic [3:0] key_len(input logic [2:0] k);
        logic [3:0] len;
        unique case (k)
            3'd0:    len = 4'd7;
            3'd1:    len = 4'd4;
            3'd2:    len = 4'd9;
            3'd3:    len = 4'd11;
            3'd4:    len = 4'd6;
            3'd5:    len = 4'd7;
            default: len = 4'd0;
        endcase
        return len;
    endfunction

    // Character p of keyword k. Positions past the end return zero, but the
    // matcher also checks the length so a zero byte never matches there.
    function automatic logic [7:0] key_char(input logic [2:0] k, input logic [5:0] p);
        logic [7:0] c;
        c = 8'h00;
        unique case (k)
            3'd0: begin
                unique case (p)
                    6'd0: c = "r";  6'd1: c = "e";  6'd2: c = "a";  6'd3: c = "d";
                    6'd4: c = "y";  6'd5: c = 8'h0D; 6'd6: c = 8'h0A;
                    default: c = 8'h00;
                endcase
            end
            3'd1: begin
                unique case (p)
                    6'd0: c = "O";  6'd1: c = "K";  6'd2: c = 8'h0D; 6'd3: c = 8'h0A;
                    default: c = 8'h00;
                endcase
            end
            3'd2: begin
                unique case (p)
                    6'd0: c = "S";  6'd1: c = "E";  6'd2: c = "N";  6'd3: c = "D";
                    6'd4: c = " ";  6'd5: c = "O";  6'd6: c = "K";  6'd7: c = 8'h0D;
                    6'd8: c = 8'h0A;
                    default: c = 8'h00;
                endcase
            end
            3'd3: begin
                unique case (p)
                    6'd0: c = "b";  6'd1: c = "u";  6'd2: c = "s";  6'd3: c = "y";
                    6'd4: c = " ";  6'd5: c = "p";  6'd6: c = ".";  6'd7: c = ".";
                    6'd8: c = ".";  6'd9: c = 8'h0D; 6'd10: c = 8'h0A;
                    default: c = 8'h00;
                endcase
            end
            3'd4: begin
                unique case (p)
                    6'd0: c = "F";  6'd1: c = "A";  6'd2: c = "I";  6'd3: c = "L";
                    6'd4: c = 8'h0D; 6'd5: c = 8'h0A;
                    default: c = 8'h00;
                endcase
            end
            3'd5: begin
                unique case (p)
                    6'd0: c = "E";  6'd1: c = "R";  6'd2: c = "R";  6'd3: c = "O";
                    6'd4: c = "R";  6'd5: c = 8'h0D; 6'd6: c = 8'h0A;
                    default: c = 8'h00;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ src/atcs_match.sv @@
`default_nettype none

// Byte-at-a-time matcher of response lines against the reply keywords.
module atcs_match (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              byte_en,
    input  wire logic [7:0]        line_byte,
    input  wire logic              line_last,
    output atcs_pkg::match_t       result
);

    logic [5:0] pos_reg, pos_next;
    logic [5:0] alive_reg, alive_next;
    logic [5:0] alive_now;

    always_comb begin
        alive_now = alive_reg;
        for (int k = 0; k < atcs_pkg::NumKeys; k++) begin
            if (!((pos_reg < {2'b00, atcs_pkg::key_len(3'(k))}) &&
                  (atcs_pkg::key_char(3'(k), pos_reg) == line_byte))) begin
                alive_now[k] = 1'b0;
            end
        end
    end

    always_comb begin
        result.hit  = 1'b0;
        result.code = atcs_pkg::RC_READY;
        for (int k = 0; k < atcs_pkg::NumKeys; k++) begin
            if (alive_now[k] &&
                ({2'b00, atcs_pkg::key_len(3'(k))} == pos_reg + 6'd1)) begin
                result.hit  = byte_en && line_last;
                result.code = 3'(k);
            end
        end
    end

    always_comb begin
        pos_next   = pos_reg;
        alive_next = alive_reg;
        if (byte_en) begin
            if (line_last) begin
                pos_next   = '0;
                alive_next = '1;
            end else begin
                alive_next = alive_now;
                if (pos_reg < atcs_pkg::PosMax) begin
                    pos_next = pos_reg + 6'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            alive_reg <= '1;
        end else begin
            pos_reg   <= pos_next;
            alive_reg <= alive_next;
        end
    end

endmodule

`default_nettype wire

@@ src/atcs_queue.sv @@
`default_nettype none

// Circular queue of command handles. The head entry is kept in a register
// read ahead from the store, so a pop returns its handle in the same cycle.
// A push and a pop may happen together; on an empty queue the pop then
// returns the handle being pushed.
module atcs_queue #(
    parameter int QUEUE_DEPTH = 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire atcs_pkg::queue_req_t               req,
    output atcs_pkg::queue_status_t                 status,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]        count
);

    localparam int PtrW = $clog2(QUEUE_DEPTH);
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    logic [7:0]      mem [QUEUE_DEPTH];
    logic [7:0]      head_reg;
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] cnt_reg, cnt_next;

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        return (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        status.push_ok  = req.push && (cnt_reg < CntW'(QUEUE_DEPTH));
        status.pop_ok   = req.pop && ((cnt_reg != '0) || status.push_ok);
        status.pop_data = (cnt_reg == '0) ? req.push_data : head_reg;

        wr_ptr_next = status.push_ok ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = status.pop_ok  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;

        unique case ({status.push_ok, status.pop_ok})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    assign count = cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (status.push_ok) begin
            mem[wr_ptr_reg] <= req.push_data;
        end
        if (status.push_ok && (wr_ptr_reg == rd_ptr_next)) begin
            head_reg <= req.push_data;
        end else begin
            head_reg <= mem[rd_ptr_next];
        end
    end

endmodule

`default_nettype wire

@@ src/atcs_outbuf.sv @@
`default_nettype none

// Two-entry output buffer: a result register plus a skid register, so the
// input side can take one more word after the receiver stalls.
module atcs_outbuf #(
    parameter int W = 24
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [W-1:0] in_data,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [W-1:0]      out_data
);

    logic         out_valid_reg, out_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    logic [W-1:0] out_data_reg, out_data_next;
    logic [W-1:0] skid_data_reg, skid_data_next;
    logic         push, pop;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign push      = in_valid && !skid_valid_reg;
    assign pop       = out_valid_reg && out_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = push;
                out_data_next  = in_data;
            end
        end else if (!out_valid_reg) begin
            out_valid_next = push;
            out_data_next  = in_data;
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

@@ src/at_command_sequencer.sv @@
// Command sequencer for a modem-style module driven by text commands.
// Input words arrive on the s_ stream; s_tuser selects the kind of word:
// queue a command handle, one byte of a response line (s_tlast marks the
// line's final byte), or a service tick (new_second set when the seconds
// clock moved). Every accepted input word yields exactly one result word on
// the m_ stream, reporting put acceptance, any handle sent, timeout and
// restart events, and the state, reply code and queue depth after the word.
// The configuration port writes the restart handle (index 0) and the
// timeout in seconds (index 1). The user must write them only while the
// block is idle; the block itself does not enforce this. Throughput is
// one word per cycle while the receiver does not stall, set by the single
// decision pass from the state registers to the result register. A
// two-entry output buffer lets one more word in after the receiver stalls;
// s_tready then drops until m_tready takes a result.
// Reset (aresetn low at a clock edge) empties the queue, returns the state
// machine to ready with reply code ready, clears the seconds counter and the
// line matcher, and restores the configuration defaults (restart handle 0,
// timeout 5 seconds). No clearing pass is needed after reset.
`default_nettype none

module at_command_sequencer #(
    parameter int QUEUE_DEPTH = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [7:0] cmd_handle, [15:8] line_byte, [16] new_second, rest zero
    input  wire logic [23:0] s_tdata,
    // [1:0] command
    input  wire logic [1:0]  s_tuser,
    input  wire logic        s_tlast,

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] put_accepted, [1] send_valid, [9:2] send_handle, [10] timeout_report,
    // [12:11] restart_cause, [14:13] fsm_state, [17:15] reply_code,
    // then queue_count (clog2(QUEUE_DEPTH+1) bits), rest zero
    output logic [((18 + $clog2(QUEUE_DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata,

    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_addr,
    input  wire logic [7:0]  cfg_wdata
);

    localparam int CntW    = $clog2(QUEUE_DEPTH + 1);
    localparam int OutBits = 18 + CntW;
    localparam int OutW    = ((OutBits + 7) / 8) * 8;

    // Configuration registers.
    logic [7:0] reset_handle_reg;
    logic [7:0] timeout_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reset_handle_reg <= '0;
            timeout_reg      <= atcs_pkg::TimeoutReset;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                atcs_pkg::CFG_RESET_HANDLE: reset_handle_reg <= cfg_wdata;
                atcs_pkg::CFG_TIMEOUT:      timeout_reg      <= cfg_wdata;
                default:                    reset_handle_reg <= reset_handle_reg;
            endcase
        end
    end

    // Input word fields.
    logic                 take;
    atcs_pkg::command_t   command;
    logic [7:0]           cmd_handle;
    logic [7:0]           line_byte;
    logic                 new_second;

    assign take       = s_tvalid && s_tready;
    assign command    = atcs_pkg::command_t'(s_tuser);
    assign cmd_handle = s_tdata[7:0];
    assign line_byte  = s_tdata[15:8];
    assign new_second = s_tdata[16];

    // Response line matcher.
    atcs_pkg::match_t match;

    atcs_match u_match (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_en   (take && (command == atcs_pkg::CMD_BYTE)),
        .line_byte (line_byte),
        .line_last (s_tlast),
        .result    (match)
    );

    // Handle queue.
    atcs_pkg::queue_req_t    q_req;
    atcs_pkg::queue_status_t q_status;
    logic [CntW-1:0]         q_count;

    atcs_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (q_req),
        .status  (q_status),
        .count   (q_count)
    );

    // Sequencer state.
    atcs_pkg::fsm_state_t state_reg, state_next;
    logic [2:0]           reply_reg, reply_next;
    logic [7:0]           sec_reg, sec_next;
    logic [7:0]           sec_inc;
    logic                 proceed;
    logic                 tmo;
    logic [1:0]           cause;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= atcs_pkg::ST_READY;
            reply_reg <= atcs_pkg::RC_READY;
            sec_reg   <= '0;
        end else begin
            state_reg <= state_next;
            reply_reg <= reply_next;
            sec_reg   <= sec_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        reply_next      = reply_reg;
        sec_next        = sec_reg;
        sec_inc         = sec_reg + 8'd1;
        proceed         = 1'b0;
        tmo             = 1'b0;
        cause           = atcs_pkg::CAUSE_NONE;
        q_req.push      = 1'b0;
        q_req.push_data = reset_handle_reg;
        q_req.pop       = 1'b0;

        if (take) begin
            unique case (command)
                atcs_pkg::CMD_QUEUE: begin
                    q_req.push      = 1'b1;
                    q_req.push_data = cmd_handle;
                end
                atcs_pkg::CMD_BYTE: begin
                    if (match.hit) begin
                        state_next = atcs_pkg::ST_GOT;
                        reply_next = match.code;
                    end
                end
                atcs_pkg::CMD_TICK: begin
                    // Seconds bookkeeping comes first; the reply handling
                    // below then sees the state it leaves behind.
                    if (new_second) begin
                        if (state_reg == atcs_pkg::ST_TIMEOUT) begin
                            state_next = atcs_pkg::ST_WAIT;
                            q_req.push = 1'b1;
                            tmo        = 1'b1;
                        end else if (state_reg == atcs_pkg::ST_WAIT) begin
                            if (sec_inc >= timeout_reg) begin
                                sec_next   = '0;
                                state_next = atcs_pkg::ST_TIMEOUT;
                            end else begin
                                sec_next = sec_inc;
                            end
                        end
                    end

                    proceed = 1'b1;
                    if (state_next == atcs_pkg::ST_GOT) begin
                        if (reply_reg == atcs_pkg::RC_BUSY ||
                            reply_reg == atcs_pkg::RC_UNKNOWN) begin
                            proceed = 1'b0;
                        end else if (reply_reg == atcs_pkg::RC_ERROR ||
                                     reply_reg == atcs_pkg::RC_FAIL) begin
                            cause      = (reply_reg == atcs_pkg::RC_ERROR) ?
                                         atcs_pkg::CAUSE_ERROR : atcs_pkg::CAUSE_FAIL;
                            reply_next = atcs_pkg::RC_UNKNOWN;
                            state_next = atcs_pkg::ST_WAIT;
                            q_req.push = 1'b1;
                            proceed    = 1'b0;
                        end else begin
                            reply_next = atcs_pkg::RC_UNKNOWN;
                            state_next = atcs_pkg::ST_READY;
                        end
                    end else if (state_next == atcs_pkg::ST_TIMEOUT) begin
                        proceed = 1'b0;
                    end

                    q_req.pop = proceed;
                    if (q_status.pop_ok) begin
                        state_next = atcs_pkg::ST_WAIT;
                    end
                end
                default: begin
                    // Unused selector: only the status is reported.
                end
            endcase
        end
    end

    // Result word.
    logic [OutW-1:0] result;
    logic            put_accepted;
    logic            send_valid;
    logic [7:0]      send_handle;

    assign put_accepted = (command == atcs_pkg::CMD_QUEUE) && q_status.push_ok;
    assign send_valid   = q_status.pop_ok;
    assign send_handle  = q_status.pop_ok ? q_status.pop_data : 8'h00;

    assign result = OutW'({q_count, reply_next, state_next, cause, tmo,
                           send_handle, send_valid, put_accepted});

    atcs_outbuf #(
        .W (OutW)
    ) u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for the AT command sequencer.
//
// Words go in on the s_ stream and every accepted word gives one status word
// on the m_ stream. The bench keeps its own model of the sequencer (handle
// queue, line matcher, seconds counter and state machine). It computes the
// status word for each input word when that word is accepted and queues it.
// Each status word taken from the block is checked field by field against
// the oldest entry in that queue.
//
// The run starts with a short directed walk: the unused selector, an empty
// tick, two handles at the byte extremes, an OK line, zero and all-ones bytes,
// a FAIL line with its restart, and a full timeout with recovery. Several
// random phases follow, each under its own restart handle and timeout. The
// random words are mostly well-formed traffic: bursts of handles, exact
// keyword lines and ticks. Some lines are cut short, padded, corrupted or
// long garbage, and a few words use the unused selector. Both sides stall
// at random, with stretches where they do not stall at all.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QDEPTH     = 8;
    localparam int QUIET_MAX  = 1000;  // cycles with no handshake before giving up
    localparam int PHASES     = 5;
    localparam int PHASE_WORDS = 370;

    // Status word, laid out as on m_tdata (queue_count is 4 bits at depth 8).
    typedef struct packed {
        logic [1:0] pad;
        logic [3:0] queue_count;
        logic [2:0] reply_code;
        logic [1:0] fsm_state;
        logic [1:0] restart_cause;
        logic       timeout_report;
        logic [7:0] send_handle;
        logic       send_valid;
        logic       put_accepted;
    } status_t;

    typedef struct {
        atcs_pkg::command_t cmd;
        logic [7:0]         handle;
        logic [7:0]         text;
        logic               last;
        logic               nsec;
        bit                 typed;   // status written out by hand below
        status_t            want;
    } stim_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = atcs_pkg::CMD_NONE;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_addr  = atcs_pkg::CFG_RESET_HANDLE;
    logic [7:0]  cfg_wdata = '0;

    at_command_sequencer #(
        .QUEUE_DEPTH(QDEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Reply keywords, indexed by their reply code; \015\012 is CR LF.
    string reply_text [6] = '{"ready\015\012", "OK\015\012", "SEND OK\015\012",
                              "busy p...\015\012", "FAIL\015\012", "ERROR\015\012"};

    // Model state and its copy of the two registers.
    logic [7:0]           q_mem [QDEPTH];
    logic [2:0]           q_wr;
    logic [2:0]           q_rd;
    logic [3:0]           q_cnt;
    atcs_pkg::fsm_state_t m_state;
    logic [2:0]           m_reply;
    logic [7:0]           m_secs;
    int                   m_pos;
    logic [5:0]           m_alive;
    logic [7:0]           c_restart_handle;
    logic [7:0]           c_timeout;

    status_t     pending_status [$];
    int          mismatches = 0;
    int          words_sent = 0;
    int          quiet_cycles = 0;
    int          rx_hold = 0;
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;

    function automatic status_t status_word(logic put, logic sent, logic [7:0] handle,
                                            logic tmo, logic [1:0] cause,
                                            atcs_pkg::fsm_state_t st,
                                            logic [2:0] reply, logic [3:0] count);
        status_t s;
        s = '0;
        s.put_accepted   = put;
        s.send_valid     = sent;
        s.send_handle    = handle;
        s.timeout_report = tmo;
        s.restart_cause  = cause;
        s.fsm_state      = st;
        s.reply_code     = reply;
        s.queue_count    = count;
        return s;
    endfunction

    // Directed walk under the reset configuration (restart handle 0, timeout 5).
    stim_row_t directed_rows [26] = '{
        // Unused selector with every field high: only the status comes back.
        '{atcs_pkg::CMD_NONE,  8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1,
          status_word(1'b0, 1'b0, 8'h00, 1'b0, atcs_pkg::CAUSE_NONE, atcs_pkg::ST_READY,
                      atcs_pkg::RC_READY, 4'd0)},
        // Tick with an empty queue sends nothing.
        '{atcs_pkg::CMD_TICK,  8'h00, 8'h00, 1'b0, 1'b1, 1'b1,
          status_word(1'b0, 1'b0, 8'h00, 1'b0, atcs_pkg::CAUSE_NONE, atcs_pkg::ST_READY,
                      atcs_pkg::RC_READY, 4'd0)},
        '{atcs_pkg::CMD_QUEUE, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b1,
          status_word(1'b1, 1'b0, 8'h00, 1'b0, atcs_pkg::CAUSE_NONE, atcs_pkg::ST_READY,
                      atcs_pkg::RC_READY, 4'd1)},
        '{atcs_pkg::CMD_QUEUE, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b1,
          status_word(1'b1, 1'b0, 8'h00, 1'b0, atcs_pkg::CAUSE_NONE, atcs_pkg::ST_READY,
                      atcs_pkg::RC_READY, 4'd2)},
        '{atcs_pkg::CMD_TICK,  8'h00, 8'h00, 1'b0, 1'b0, 1'b1,
          status_word(1'b0, 1'b1, 8'hFF, 1'b0, atcs_pkg::CAUSE_NONE, atcs_pkg::ST_WAIT,
                      atcs_pkg::RC_READY, 4'd1)},
        // "OK" line.
        '{atcs_pkg::CMD_BYTE,  8'h00, "O",   1'b0, 1'b0, 1'b0, '0},
        '{atcs_pkg::CMD_BYTE,  8'h00, "K",   1'b0, 1'b0, 1'b0, '0},
        '{atcs_pkg::CMD_BYTE,  8'h00, 8'h0D, 1'b0, 1'b0, 1'b0, '0},
        '{atcs_pkg::CMD_BYTE,  8'h00, 8'h0A, 1'b1, 1'b0, 1'b1,
          status_word(1'b0, 1'b0, 8'h00, 1'b0, atcs_pkg::CAUSE_NONE, atcs_pkg::ST_GOT,
                      atcs_pkg::RC_OK, 4'd1)},
        // Positive reply: back to ready, then the next handle goes out.
        '{atcs_pkg::CMD_TICK,  8'h00, 8'h00, 1'b0, 1'b0, 1'b1,
          status_word(1'b0, 1'b1, 8'h00, 1'b0, atcs_pkg::CAUSE_NONE, atcs_pkg::ST_WAIT,
                      atcs_pkg::RC_UNKNOWN, 4'd0)},
        // One-byte lines of zero and all ones match nothing.
        '{atcs_pkg::CMD_BYTE,  8'h00, 8'h00, 1'b1, 1'b0, 1'b0, '0},
        '{atcs_pkg::CMD_BYTE,  8'h00, 8'hFF, 1'b1, 1'b0, 1'b0, '0},
        // "FAIL" line.
        '{atcs_pkg::CMD_BYTE,  8'h00, "F",   1'b0, 1'b0, 1'b0, '0},
        '{atcs_pkg::CMD_BYTE,  8'h00, "A",   1'b0, 1'b0, 1'b0, '0},
        '{atcs_pkg::CMD_BYTE,  8'h00, "I",   1'b0, 1'b0, 1'b0, '0},
        '{atcs_pkg::CMD_BYTE,  8'h00, "L",   1'b0, 1'b0, 1'b0, '0},
        '{atcs_pkg::CMD_BYTE,  8'h00, 8'h0D, 1'b0, 1'b0, 1'b0, '0},
        '{atcs_pkg::CMD_BYTE,  8'h00, 8'h0A, 1'b1, 1'b0, 1'b1,
          status_word(1'b0, 1'b0, 8'h00, 1'b0, atcs_pkg::CAUSE_NONE, atcs_pkg::ST_GOT,
                      atcs_pkg::RC_FAIL, 4'd0)},
        // FAIL queues the restart handle; the new second is ignored here.
        '{atcs_pkg::CMD_TICK,  8'h00, 8'h00, 1'b0, 1'b1, 1'b1,
          status_word(1'b0, 1'b0, 8'h00, 1'b0, atcs_pkg::CAUSE_FAIL, atcs_pkg::ST_WAIT,
                      atcs_pkg::RC_UNKNOWN, 4'd1)},
        // A tick while waiting still sends the queued restart handle.
        '{atcs_pkg::CMD_TICK,  8'h00, 8'h00, 1'b0, 1'b0, 1'b1,
          status_word(1'b0, 1'b1, 8'h00, 1'b0, atcs_pkg::CAUSE_NONE, atcs_pkg::ST_WAIT,
                      atcs_pkg::RC_UNKNOWN, 4'd0)},
        // Five new seconds while waiting reach the timeout state.
        '{atcs_pkg::CMD_TICK,  8'h00, 8'h00, 1'b0, 1'b1, 1'b0, '0},
        '{atcs_pkg::CMD_TICK,  8'h00, 8'h00, 1'b0, 1'b1, 1'b0, '0},
        '{atcs_pkg::CMD_TICK,  8'h00, 8'h00, 1'b0, 1'b1, 1'b0, '0},
        '{atcs_pkg::CMD_TICK,  8'h00, 8'h00, 1'b0, 1'b1, 1'b0, '0},
        '{atcs_pkg::CMD_TICK,  8'h00, 8'h00, 1'b0, 1'b1, 1'b1,
          status_word(1'b0, 1'b0, 8'h00, 1'b0, atcs_pkg::CAUSE_NONE, atcs_pkg::ST_TIMEOUT,
                      atcs_pkg::RC_UNKNOWN, 4'd0)},
        // Leaving the timeout queues the restart handle and sends it at once.
        '{atcs_pkg::CMD_TICK,  8'h00, 8'h00, 1'b0, 1'b1, 1'b1,
          status_word(1'b0, 1'b1, 8'h00, 1'b1, atcs_pkg::CAUSE_NONE, atcs_pkg::ST_WAIT,
                      atcs_pkg::RC_UNKNOWN, 4'd0)}
    };

    function automatic void clear_model();
        foreach (q_mem[i]) q_mem[i] = '0;
        q_wr             = '0;
        q_rd             = '0;
        q_cnt            = '0;
        m_state          = atcs_pkg::ST_READY;
        m_reply          = atcs_pkg::RC_READY;
        m_secs           = '0;
        m_pos            = 0;
        m_alive          = '1;
        c_restart_handle = '0;
        c_timeout        = atcs_pkg::TimeoutReset;
    endfunction

    // A full queue drops the handle; the caller decides whether that is reported.
    function automatic logic store_handle(logic [7:0] h);
        if (int'(q_cnt) >= QDEPTH) return 1'b0;
        q_mem[q_wr] = h;
        q_wr        = q_wr + 3'd1;
        q_cnt       = q_cnt + 4'd1;
        return 1'b1;
    endfunction

    // Applies one input word to the model and returns the status word it gives.
    function automatic status_t advance_sequencer(atcs_pkg::command_t cmd,
                                                  logic [7:0] handle,
                                                  logic [7:0] text, logic last,
                                                  logic nsec);
        status_t s;
        logic    go_on;
        s     = '0;
        go_on = 1'b1;
        case (cmd)
            atcs_pkg::CMD_QUEUE: begin
                s.put_accepted = store_handle(handle);
            end
            atcs_pkg::CMD_BYTE: begin
                // A keyword stays alive while every byte so far matches it.
                for (int k = 0; k < atcs_pkg::NumKeys; k++) begin
                    if (!(m_pos < reply_text[k].len() && reply_text[k][m_pos] == text))
                        m_alive[k] = 1'b0;
                end
                if (last) begin
                    for (int k = 0; k < atcs_pkg::NumKeys; k++) begin
                        if (m_alive[k] && reply_text[k].len() == m_pos + 1) begin
                            m_state = atcs_pkg::ST_GOT;
                            m_reply = 3'(k);
                        end
                    end
                    m_pos   = 0;
                    m_alive = '1;
                end else if (m_pos < int'(atcs_pkg::PosMax)) begin
                    m_pos++;
                end
            end
            atcs_pkg::CMD_TICK: begin
                if (nsec) begin
                    if (m_state == atcs_pkg::ST_TIMEOUT) begin
                        m_state = atcs_pkg::ST_WAIT;
                        void'(store_handle(c_restart_handle));
                        s.timeout_report = 1'b1;
                    end else if (m_state == atcs_pkg::ST_WAIT) begin
                        // The counter is only cleared by a timeout, so it carries
                        // over from one command to the next.
                        m_secs = m_secs + 8'd1;
                        if (m_secs >= c_timeout) begin
                            m_secs  = '0;
                            m_state = atcs_pkg::ST_TIMEOUT;
                        end
                    end
                end
                if (m_state == atcs_pkg::ST_GOT) begin
                    if (m_reply == atcs_pkg::RC_BUSY || m_reply == atcs_pkg::RC_UNKNOWN) begin
                        go_on = 1'b0;
                    end else if (m_reply == atcs_pkg::RC_ERROR ||
                                 m_reply == atcs_pkg::RC_FAIL) begin
                        s.restart_cause = (m_reply == atcs_pkg::RC_ERROR) ?
                                          atcs_pkg::CAUSE_ERROR : atcs_pkg::CAUSE_FAIL;
                        m_reply = atcs_pkg::RC_UNKNOWN;
                        m_state = atcs_pkg::ST_WAIT;
                        void'(store_handle(c_restart_handle));
                        go_on = 1'b0;
                    end else begin
                        m_reply = atcs_pkg::RC_UNKNOWN;
                        m_state = atcs_pkg::ST_READY;
                    end
                end else if (m_state == atcs_pkg::ST_TIMEOUT) begin
                    go_on = 1'b0;
                end
                if (go_on && q_cnt != 4'd0) begin
                    s.send_valid  = 1'b1;
                    s.send_handle = q_mem[q_rd];
                    q_rd          = q_rd + 3'd1;
                    q_cnt         = q_cnt - 4'd1;
                    m_state       = atcs_pkg::ST_WAIT;
                end
            end
            default: ;
        endcase
        s.fsm_state   = m_state;
        s.reply_code  = m_reply;
        s.queue_count = q_cnt;
        return s;
    endfunction

    // Wait drawn per word; the steady flag flips now and then to give
    // stretches with no idling at all.
    function automatic int pick_wait(inout bit steady);
        if ($urandom_range(0, 99) < 4) steady = !steady;
        return steady ? 0 : int'($urandom_range(0, 11));
    endfunction

    task automatic flag_mismatch(string msg);
        mismatches++;
        $display("%0t mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want) flag_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    // Sends one word. On return the word has just been accepted at this edge,
    // and s_tvalid is still high: the next call or wait_idle takes it over.
    task automatic send_word(atcs_pkg::command_t cmd, logic [7:0] handle, logic [7:0] text,
                             logic last, logic nsec, bit typed, status_t want);
        int      gap;
        status_t model;
        gap = pick_wait(tx_steady);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'd0, nsec, text, handle};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        model = advance_sequencer(cmd, handle, text, last, nsec);
        pending_status.push_back(typed ? want : model);
        if (cmd != atcs_pkg::CMD_NONE) words_sent++;
    endtask

    // Holds the input back until every status word is in.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_status.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // Both registers, one after the other, while the block is idle.
    task automatic write_config(logic [7:0] restart_handle, logic [7:0] timeout_secs);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= atcs_pkg::CFG_RESET_HANDLE;
        cfg_wdata <= restart_handle;
        @(posedge aclk);
        cfg_addr  <= atcs_pkg::CFG_TIMEOUT;
        cfg_wdata <= timeout_secs;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        c_restart_handle = restart_handle;
        c_timeout        = timeout_secs;
    endtask

    // One response line: mostly an exact keyword, otherwise a truncated or
    // padded keyword, a keyword with one bit flipped, or a run of garbage that
    // is sometimes long enough to saturate the line position.
    task automatic send_line();
        logic [7:0] line_buf [$];
        int         kind;
        int         k;
        int         n;
        kind = $urandom_range(0, 9);
        k    = $urandom_range(0, atcs_pkg::NumKeys - 1);
        for (int i = 0; i < reply_text[k].len(); i++) line_buf.push_back(8'(reply_text[k][i]));
        if (kind == 7) begin
            if ($urandom_range(0, 1) == 1) begin
                n = $urandom_range(1, line_buf.size() - 1);
                repeat (n) void'(line_buf.pop_back());
            end else begin
                repeat ($urandom_range(1, 4)) line_buf.push_back(8'($urandom_range(0, 255)));
            end
        end else if (kind == 8) begin
            n = $urandom_range(0, line_buf.size() - 1);
            line_buf[n] = line_buf[n] ^ (8'h01 << $urandom_range(0, 7));
        end else if (kind == 9) begin
            line_buf.delete();
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 80) : $urandom_range(1, 12);
            repeat (n) begin
                line_buf.push_back(($urandom_range(0, 4) == 0) ? 8'h00
                                                               : 8'($urandom_range(0, 255)));
            end
        end
        for (int i = 0; i < line_buf.size(); i++) begin
            send_word(atcs_pkg::CMD_BYTE, 8'($urandom), line_buf[i],
                      i == line_buf.size() - 1, 1'($urandom), 1'b0, '0);
        end
    endtask

    task automatic run_random(int count);
        int roll;
        int stop_at;
        stop_at = words_sent + count;
        while (words_sent < stop_at) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                send_word(atcs_pkg::CMD_NONE, 8'($urandom), 8'($urandom), 1'($urandom),
                          1'($urandom), 1'b0, '0);
            end else if (roll < 23) begin
                // Bursts up to ten long overflow the queue now and then.
                repeat ($urandom_range(1, 10)) begin
                    send_word(atcs_pkg::CMD_QUEUE, 8'($urandom), 8'($urandom),
                              1'($urandom), 1'($urandom), 1'b0, '0);
                end
            end else if (roll < 55) begin
                send_line();
            end else begin
                send_word(atcs_pkg::CMD_TICK, 8'($urandom), 8'($urandom), 1'($urandom),
                          ($urandom_range(0, 99) < 55), 1'b0, '0);
            end
            if ($urandom_range(0, 199) == 0) wait_idle();
        end
    endtask

    // Result side: check every accepted status word, then draw the stall
    // before the next one.
    always @(posedge aclk) begin
        status_t got;
        status_t want;
        int      w;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold = 0;
        end else if (m_tvalid && m_tready) begin
            got = status_t'(m_tdata);
            if (pending_status.size() == 0) begin
                flag_mismatch($sformatf("status word %h with nothing expected", m_tdata));
            end else begin
                want = pending_status.pop_front();
                check_field("put_accepted",   int'(got.put_accepted),   int'(want.put_accepted));
                check_field("send_valid",     int'(got.send_valid),     int'(want.send_valid));
                check_field("send_handle",    int'(got.send_handle),    int'(want.send_handle));
                check_field("timeout_report", int'(got.timeout_report), int'(want.timeout_report));
                check_field("restart_cause",  int'(got.restart_cause),  int'(want.restart_cause));
                check_field("fsm_state",      int'(got.fsm_state),      int'(want.fsm_state));
                check_field("reply_code",     int'(got.reply_code),     int'(want.reply_code));
                check_field("queue_count",    int'(got.queue_count),    int'(want.queue_count));
            end
            w = pick_wait(rx_steady);
            if (w > 0) begin
                m_tready <= 1'b0;
                rx_hold = w;
            end else begin
                m_tready <= 1'b1;
            end
        end else if (rx_hold > 0) begin
            rx_hold--;
            if (rx_hold == 0) m_tready <= 1'b1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog: too long without a handshake on either side ends the run.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_MAX) begin
                $display("[at_command_sequencer] ERROR");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        logic [7:0] restart_handle;
        logic [7:0] timeout_secs;
        clear_model();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            send_word(directed_rows[i].cmd, directed_rows[i].handle, directed_rows[i].text,
                      directed_rows[i].last, directed_rows[i].nsec, directed_rows[i].typed,
                      directed_rows[i].want);
        end
        wait_idle();

        // Phases run from the timeout extremes down to small values, so the
        // seconds counter left over from a long timeout is often above the new
        // setting. Zero times out on the first new second.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin restart_handle = 8'hA5; timeout_secs = 8'd1; end
                1: begin restart_handle = 8'hFF; timeout_secs = 8'd255; end
                2: begin restart_handle = 8'h00; timeout_secs = 8'd0; end
                3: begin restart_handle = 8'($urandom); timeout_secs = 8'd3; end
                default: begin
                    restart_handle = 8'($urandom);
                    timeout_secs   = 8'($urandom_range(1, 12));
                end
            endcase
            write_config(restart_handle, timeout_secs);
            run_random(PHASE_WORDS);
            wait_idle();
        end

        if (mismatches == 0 && pending_status.size() == 0) begin
            $display("[at_command_sequencer] OK");
        end else begin
            $display("[at_command_sequencer] ERROR");
        end
        $finish;
    end

endmodule
